/* hw/rtl/arlt_pkg.sv */
// Package for the array list table: capacity, field widths, request and
// status codes, and the request and response payload structs.
// No dependencies.
package arlt_pkg;

  localparam int CAPACITY = 64;

  // Widths derived from the capacity
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  // Fixed field widths of the transfer payloads
  localparam int TYPE_W = 3;
  localparam int POS_W  = 7;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;
  localparam int OCNT_W = 7;

  // Request codes
  localparam logic [TYPE_W-1:0] REQ_APPEND    = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_INSERT    = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_DELETE    = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_OVERWRITE = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_SEARCH    = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [TYPE_W-1:0]        req_type;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic                     found;
    logic signed [WORD_W-1:0] found_value;
    logic [OCNT_W-1:0]        count;
  } rsp_t;

endpackage

/* hw/rtl/arlt_mem.sv */
// Entry store of the array list table: one write port, one read port with
// registered read data. Depends on arlt_pkg.
module arlt_mem
  import arlt_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [CAPACITY];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/array_list_table_unit.sv */
// Top level of the array list table: request sequencer, entry count and
// response register. Depends on arlt_pkg and arlt_mem.
//
// A request transfers when start is high and busy is low; its response shows
// on rsp for exactly one cycle with done high, and must be taken then, since
// the block has no way to be stalled. Append, overwrite, rejected requests
// and unused codes finish at once: done rises in the cycle after the transfer
// and busy stays low. Insert, delete and search walk the entry store through
// its single read port and single write port, one entry per cycle: insert
// moves count-position entries, delete moves count-position-1 entries and
// search reads count entries. Once the last read has returned, the walk
// ends: busy falls and done rises in the same cycle.
module array_list_table_unit
  import arlt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  left;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] pend_dst;
  logic              pend;
  logic              hit;
  req_t              req_q;

  logic              accept;
  logic              full;
  logic              ins_ok;
  logic              del_ok;
  logic [CMP_W-1:0]  pos_x;
  logic [CMP_W-1:0]  cnt_x;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [WORD_W-1:0] mem_rdata;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Bounds checks against the current count
  assign pos_x  = CMP_W'(req.position);
  assign cnt_x  = CMP_W'(count);
  assign full   = (count == CNT_W'(CAPACITY));
  assign ins_ok = (pos_x <= cnt_x);
  assign del_ok = (pos_x < cnt_x);

  // Drive the store ports: direct writes at transfer, moves during a walk
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = req.value;
    mem_re    = (state == S_WALK) && (left != '0);
    if (state == S_IDLE) begin
      if (accept) begin
        if (req.req_type == REQ_APPEND && !full) begin
          mem_we    = 1'b1;
          mem_waddr = count[ADDR_W-1:0];
        end else if (req.req_type == REQ_OVERWRITE && del_ok) begin
          mem_we    = 1'b1;
          mem_waddr = req.position[ADDR_W-1:0];
        end
      end
    end else begin
      if (pend && req_q.req_type != REQ_SEARCH) begin
        mem_we    = 1'b1;
        mem_waddr = pend_dst;
        mem_wdata = mem_rdata;
      end else if (!pend && left == '0 && req_q.req_type == REQ_INSERT) begin
        mem_we    = 1'b1;
        mem_waddr = req_q.position[ADDR_W-1:0];
        mem_wdata = req_q.value;
      end
    end
  end

  arlt_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (addr),
    .rdata (mem_rdata)
  );

  // Sequencer, count and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      left  <= '0;
      pend  <= 1'b0;
      hit   <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      pend <= (state == S_WALK) && (left != '0);
      case (state)
        S_IDLE: begin
          if (accept) begin
            req_q           <= req;
            hit             <= 1'b0;
            rsp.status      <= ST_OK;
            rsp.found       <= 1'b0;
            rsp.found_value <= '0;
            rsp.count       <= OCNT_W'(count);
            case (req.req_type)
              REQ_APPEND: begin
                done <= 1'b1;
                if (full) begin
                  rsp.status <= ST_FULL;
                end else begin
                  count     <= count + 1'b1;
                  rsp.count <= OCNT_W'(count + 1'b1);
                end
              end
              REQ_INSERT: begin
                if (full) begin
                  done       <= 1'b1;
                  rsp.status <= ST_FULL;
                end else if (!ins_ok) begin
                  done       <= 1'b1;
                  rsp.status <= ST_BADPOS;
                end else begin
                  state <= S_WALK;
                  left  <= CNT_W'(cnt_x - pos_x);
                  addr  <= ADDR_W'(count - 1'b1);
                end
              end
              REQ_DELETE: begin
                if (!del_ok) begin
                  done       <= 1'b1;
                  rsp.status <= ST_BADPOS;
                end else begin
                  state <= S_WALK;
                  left  <= CNT_W'(cnt_x - pos_x - 1'b1);
                  addr  <= ADDR_W'(req.position + 1'b1);
                end
              end
              REQ_OVERWRITE: begin
                done <= 1'b1;
                if (!del_ok) begin
                  rsp.status <= ST_BADPOS;
                end
              end
              REQ_SEARCH: begin
                state <= S_WALK;
                left  <= count;
                addr  <= '0;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_WALK: begin
          // Advance the read pointer; insert walks down, the others walk up
          if (left != '0) begin
            left <= left - 1'b1;
            if (req_q.req_type == REQ_INSERT) begin
              addr     <= addr - 1'b1;
              pend_dst <= addr + 1'b1;
            end else begin
              addr     <= addr + 1'b1;
              pend_dst <= addr - 1'b1;
            end
          end
          // Compare returning read data for a search
          if (pend && req_q.req_type == REQ_SEARCH && mem_rdata == req_q.value) begin
            hit <= 1'b1;
          end
          // Finish once all reads have returned
          if (left == '0 && !pend) begin
            state           <= S_IDLE;
            done            <= 1'b1;
            rsp.status      <= ST_OK;
            rsp.found       <= 1'b0;
            rsp.found_value <= '0;
            rsp.count       <= OCNT_W'(count);
            case (req_q.req_type)
              REQ_INSERT: begin
                count     <= count + 1'b1;
                rsp.count <= OCNT_W'(count + 1'b1);
              end
              REQ_DELETE: begin
                count     <= count - 1'b1;
                rsp.count <= OCNT_W'(count - 1'b1);
              end
              REQ_SEARCH: begin
                rsp.found <= hit;
                if (hit) begin
                  rsp.found_value <= req_q.value;
                end
              end
              default: begin
                rsp.status <= ST_OK;
              end
            endcase
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // A move never writes the entry it reads in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != addr))
    else $error("read and write at the same entry");

  // A full status only comes back with a full list
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_FULL) |-> (rsp.count == OCNT_W'(CAPACITY)))
    else $error("full status with room left");

  // Only a search reports a hit
  a_found_search: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.found) |-> (req_q.req_type == REQ_SEARCH && rsp.status == ST_OK))
    else $error("hit reported outside a search");
`endif

endmodule
